/* rtl/xorshift128_random_generator_macros.svh */
`ifndef XORSHIFT128_RANDOM_GENERATOR_MACROS_SVH
`define XORSHIFT128_RANDOM_GENERATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define XS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define XS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/xs128_pkg.sv */
`default_nettype none

package xs128_pkg;

  localparam int WORD_W = 32;
  localparam int NUM_WORDS = 4;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [2*WORD_W-1:0] prod_t;

  typedef enum logic [1:0] {
    OP_SEED  = 2'd0,
    OP_DRAW  = 2'd1,
    OP_RANGE = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  localparam word_t SEED_MULT = 32'd1812433253;
  localparam word_t RESET_W0 = 32'd123456789;
  localparam word_t RESET_W1 = 32'd362436069;
  localparam word_t RESET_W2 = 32'd521288629;
  localparam word_t RESET_W3 = 32'd88675123;

  localparam int SHIFT_A = 11;
  localparam int SHIFT_B = 19;
  localparam int SHIFT_C = 8;
  localparam int SHIFT_SEED = 30;

  function automatic word_t seed_mix(input word_t x);
    return x ^ (x >> SHIFT_SEED);
  endfunction

  function automatic word_t draw_next(input word_t w0, input word_t w3);
    word_t t;
    t = w0 ^ (w0 << SHIFT_A);
    return (w3 ^ (w3 >> SHIFT_B)) ^ (t ^ (t >> SHIFT_C));
  endfunction

endpackage

`default_nettype wire

/* rtl/xorshift128_random_generator.sv */
// From request acceptance to m_tvalid, a raw draw, an empty range or an unused opcode goes straight
// to ST_DONE, a range draw passes ST_RANGE_MUL and ST_RANGE_ADD, and seeding passes ST_SEED_MUL and
// ST_SEED_ADD once per state word, plus any output stall in ST_DONE. One request is in flight at a
// time; the next is taken the cycle after the result is registered.
// Each multiply uses the shared 32x32 multiplier, whose product is registered. Synchronous
// active-high reset loads the standard xorshift128 state words.
`default_nettype none
`include "xorshift128_random_generator_macros.svh"

module xorshift128_random_generator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [95:0] s_tdata,  // seed_value, range_min, range_max
  input  wire logic [1:0]  s_tuser,  // opcode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata   // raw_word, ranged_value
);
  import xs128_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_ADD,
    ST_RANGE_MUL,
    ST_RANGE_ADD,
    ST_DONE
  } state_t;

  state_t  state;
  opcode_t op;
  word_t   words [NUM_WORDS];
  word_t   rmin;
  word_t   rmax;
  word_t   mul_a;
  word_t   mul_b;
  prod_t   prod;
  logic    span_full;
  logic [1:0] cnt;
  word_t   res_raw;
  word_t   res_ranged;

  word_t   in_seed;
  word_t   in_min;
  word_t   in_max;
  opcode_t in_op;
  word_t   draw_word;
  word_t   span_low;
  word_t   seed_word;
  word_t   offset;

  assign in_seed = s_tdata[31:0];
  assign in_min  = s_tdata[63:32];
  assign in_max  = s_tdata[95:64];
  assign in_op   = opcode_t'(s_tuser);

  assign draw_word = draw_next(words[0], words[3]);
  assign span_low  = in_max - in_min + 32'd1;
  assign seed_word = prod[WORD_W-1:0] + word_t'(cnt) + 32'd1;
  assign offset    = span_full ? mul_a : prod[2*WORD_W-1:WORD_W];

  assign s_tready = (state == ST_IDLE);

  xs128_mul u_mul (
    .clk     (clk),
    .a       (mul_a),
    .b       (mul_b),
    .product (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      words[0] <= RESET_W0;
      words[1] <= RESET_W1;
      words[2] <= RESET_W2;
      words[3] <= RESET_W3;
      cnt      <= 2'd0;
    end else begin
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op   <= in_op;
            rmin <= in_min;
            rmax <= in_max;
            unique case (in_op)
              OP_SEED: begin
                mul_a <= seed_mix(in_seed);
                mul_b <= SEED_MULT;
                cnt   <= 2'd0;
                state <= ST_SEED_MUL;
              end
              OP_DRAW: begin
                words[0]   <= words[1];
                words[1]   <= words[2];
                words[2]   <= words[3];
                words[3]   <= draw_word;
                res_raw    <= draw_word;
                res_ranged <= '0;
                state      <= ST_DONE;
              end
              OP_RANGE: begin
                if ($signed(in_min) >= $signed(in_max)) begin
                  res_raw    <= '0;
                  res_ranged <= in_min;
                  state      <= ST_DONE;
                end else begin
                  words[0]  <= words[1];
                  words[1]  <= words[2];
                  words[2]  <= words[3];
                  words[3]  <= draw_word;
                  mul_a     <= draw_word;
                  mul_b     <= span_low;
                  span_full <= (span_low == '0);
                  state     <= ST_RANGE_MUL;
                end
              end
              default: begin
                res_raw    <= '0;
                res_ranged <= '0;
                state      <= ST_DONE;
              end
            endcase
          end
        end
        ST_SEED_MUL: begin
          state <= ST_SEED_ADD;
        end
        ST_SEED_ADD: begin
          words[cnt] <= seed_word;
          if (cnt == 2'd3) begin
            res_raw    <= '0;
            res_ranged <= '0;
            state      <= ST_DONE;
          end else begin
            mul_a <= seed_mix(seed_word);
            cnt   <= cnt + 2'd1;
            state <= ST_SEED_MUL;
          end
        end
        ST_RANGE_MUL: begin
          state <= ST_RANGE_ADD;
        end
        ST_RANGE_ADD: begin
          res_raw    <= mul_a;
          res_ranged <= rmin + offset;
          state      <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {res_ranged, res_raw};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `XS_ASSERT_NEXT(a_seed_start, s_tvalid && s_tready && s_tuser == OP_SEED, state == ST_SEED_MUL && cnt == 2'd0, "seed request did not start the multiply chain")
  `XS_ASSERT_NEXT(a_draw_fast, s_tvalid && s_tready && s_tuser == OP_DRAW, state == ST_DONE && res_ranged == '0, "raw draw did not finish in one step")
  `XS_ASSERT_NOW(a_range_bounds, state == ST_DONE && op == OP_RANGE && $signed(rmin) < $signed(rmax), $signed(res_ranged) >= $signed(rmin) && $signed(res_ranged) <= $signed(rmax), "range result outside bounds")

endmodule

`default_nettype wire

/* rtl/xs128_mul.sv */
`default_nettype none

module xs128_mul (
  input  wire logic             clk,
  input  wire xs128_pkg::word_t a,
  input  wire xs128_pkg::word_t b,
  output xs128_pkg::prod_t      product
);
  import xs128_pkg::*;

  always_ff @(posedge clk) begin
    product <= prod_t'(a) * prod_t'(b);
  end

endmodule

`default_nettype wire

/* tb/sv/tb_xorshift128_random_generator.sv */
`timescale 1ns / 1ps

module tb_xorshift128_random_generator;
  import xs128_pkg::*;

  localparam word_t INT_MIN_W = 32'h8000_0000;
  localparam word_t INT_MAX_W = 32'h7fff_ffff;
  localparam word_t SIGN_BIT = 32'h8000_0000;
  localparam int RANDOM_REQUESTS = 750;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int CYCLE_LIMIT = 500000;

  // Tracks the four generator words and the results still owed by the block.
  class generator_mirror;
    word_t gen_words[NUM_WORDS];
    logic [63:0] owed_results[$];
    int errors;

    function new();
      gen_words[0] = RESET_W0;
      gen_words[1] = RESET_W1;
      gen_words[2] = RESET_W2;
      gen_words[3] = RESET_W3;
      errors = 0;
    endfunction

    function word_t chain_word(word_t prev, word_t addend);
      return SEED_MULT * (prev ^ (prev >> SHIFT_SEED)) + addend;
    endfunction

    function word_t advance();
      word_t t;
      word_t last;
      t = gen_words[0] ^ (gen_words[0] << SHIFT_A);
      last = gen_words[3];
      gen_words[0] = gen_words[1];
      gen_words[1] = gen_words[2];
      gen_words[2] = last;
      gen_words[3] = (last ^ (last >> SHIFT_B)) ^ (t ^ (t >> SHIFT_C));
      return gen_words[3];
    endfunction

    function void take_request(opcode_t op, word_t seed, word_t lo, word_t hi);
      word_t raw;
      word_t ranged;
      word_t w;
      logic [63:0] span;
      logic [63:0] prod;
      raw = '0;
      ranged = '0;
      case (op)
        OP_SEED: begin
          gen_words[0] = chain_word(seed, 32'd1);
          for (int k = 0; k < 3; k++) begin
            gen_words[k+1] = chain_word(gen_words[k], word_t'(k + 2));
          end
        end
        OP_DRAW: begin
          raw = advance();
        end
        OP_RANGE: begin
          if ((lo ^ SIGN_BIT) >= (hi ^ SIGN_BIT)) begin
            ranged = lo;
          end else begin
            w = advance();
            span = {32'd0, (hi ^ SIGN_BIT) - (lo ^ SIGN_BIT)} + 64'd1;
            prod = {32'd0, w} * span;
            raw = w;
            ranged = lo + prod[63:32];
          end
        end
        default: begin
        end
      endcase
      owed_results.push_back({ranged, raw});
    endfunction

    function void check_result(logic [63:0] data);
      logic [63:0] owed;
      if (owed_results.size() == 0) begin
        $error("unexpected result: raw_word %h ranged_value %0d",
               data[31:0], $signed(data[63:32]));
        errors++;
        return;
      end
      owed = owed_results.pop_front();
      if (data[31:0] !== owed[31:0]) begin
        $error("raw_word mismatch: expected %h, actual %h", owed[31:0], data[31:0]);
        errors++;
      end
      if (data[63:32] !== owed[63:32]) begin
        $error("ranged_value mismatch: expected %0d, actual %0d",
               $signed(owed[63:32]), $signed(data[63:32]));
        errors++;
      end
    endfunction

    function int outstanding();
      return owed_results.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [95:0] s_tdata;
  logic [1:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [63:0] m_tdata;

  generator_mirror mirror = new();
  bit no_idle = 1'b0;
  bit hold_off_req = 1'b0;
  bit holding = 1'b0;
  int cycles = 0;

  xorshift128_random_generator u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      mirror.check_result(m_tdata);
    end
  end

  // The receiver stalls at random; on request it holds off for a long stretch.
  initial begin
    int stall;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        holding = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        holding = 1'b0;
      end else if (no_idle || $urandom_range(0, 99) < 65) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        stall = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  // Called at a falling edge; returns at a falling edge after the request and its gap.
  task automatic send_request(opcode_t op, word_t seed, word_t lo, word_t hi);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {hi, lo, seed};
    do @(posedge clk); while (!s_tready);
    mirror.take_request(op, seed, lo, hi);
    @(negedge clk);
    if (no_idle || holding || $urandom_range(0, 99) < 55) begin
      gap = 0;
    end else if ($urandom_range(0, 99) < 90) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_random(output bit counted);
    int pick;
    opcode_t op;
    word_t seed;
    word_t lo;
    word_t hi;
    seed = $urandom;
    lo = $urandom;
    hi = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      op = OP_SEED;
    end else if (pick < 45) begin
      op = OP_DRAW;
    end else if (pick < 96) begin
      op = OP_RANGE;
    end else begin
      op = OP_NONE;
    end
    if (op == OP_RANGE) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        hi = lo + $urandom_range(1, 20);
      end else if (pick < 55) begin
        lo = INT_MIN_W + $urandom_range(0, 3);
        hi = INT_MAX_W - $urandom_range(0, 3);
      end else if (pick < 65) begin
        hi = lo;
      end else if (pick < 75) begin
        hi = lo - $urandom_range(1, 1000);
      end
    end
    send_request(op, seed, lo, hi);
    counted = (op != OP_NONE);
  endtask

  initial begin
    int sent;
    bit counted;
    bit pressure_done;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_NONE;
    sent = 0;
    pressure_done = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_request(OP_DRAW, '0, '0, '0);
    send_request(OP_DRAW, '1, '1, '1);
    send_request(OP_RANGE, '0, INT_MIN_W, INT_MAX_W);
    send_request(OP_RANGE, '1, 32'd5, 32'd5);
    send_request(OP_RANGE, '0, INT_MAX_W, INT_MIN_W);
    send_request(OP_RANGE, '0, INT_MIN_W, INT_MIN_W + 32'd1);
    send_request(OP_RANGE, '0, INT_MAX_W - 32'd1, INT_MAX_W);
    send_request(OP_RANGE, '0, '1, '0);
    send_request(OP_NONE, '1, '1, '1);
    send_request(OP_SEED, '0, '1, '1);
    send_request(OP_DRAW, '0, '0, '0);
    send_request(OP_RANGE, '0, -32'sd100, 32'sd100);
    send_request(OP_SEED, '1, '0, '0);
    send_request(OP_DRAW, '0, '0, '0);
    send_request(OP_RANGE, '1, '0, INT_MAX_W);
    send_request(OP_SEED, INT_MIN_W, '0, '0);
    send_request(OP_DRAW, '0, '0, '0);
    send_request(OP_RANGE, '0, INT_MIN_W, INT_MIN_W);
    send_request(OP_RANGE, '0, INT_MAX_W, INT_MAX_W);
    send_request(OP_RANGE, '0, INT_MIN_W, '1);
    send_request(OP_NONE, '0, '0, '0);
    send_request(OP_DRAW, '0, '0, '0);

    while (sent < RANDOM_REQUESTS) begin
      no_idle = (sent >= 150 && sent < 250);
      if (sent >= 450 && !pressure_done) begin
        hold_off_req = 1'b1;
        pressure_done = 1'b1;
      end
      send_random(counted);
      if (counted) begin
        sent++;
      end
    end
    no_idle = 1'b0;
    s_tvalid <= 1'b0;

    while (mirror.outstanding() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
